// ===== src/bnms_pkg.sv =====
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants of the box non-maximum suppression core.
// ----------------------------------------------------------------------------
package bnms_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int EMIT_W   = 7;
	localparam int MAX_EMIT = 64;
	localparam int EXT_W    = 18;   // box extent incl. the +1 unit
	localparam int OPD_W    = 24;   // shared multiplier operand
	localparam int PROD_W   = 48;
	localparam int UNI_W    = 38;   // union of two areas
	localparam int ACC_W    = 56;   // threshold * union
	localparam int UNI_LO_W = 20;
	localparam logic signed [EXT_W-1:0] UNIT = EXT_W'(256);

	// configuration register indexes
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MAX_OUT   = 1'b1;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] bottom;
		logic signed [15:0] right;
		logic signed [15:0] top;
		logic [15:0]        score;
		logic [2:0]         cls;
		logic               dir;
		logic [15:0]        tag;
	} entry_t;

	typedef enum logic [1:0] {
		MUL_AREA  = 2'd0,
		MUL_CROSS = 2'd1,
		MUL_TLO   = 2'd2,
		MUL_THI   = 2'd3
	} mul_op_t;

	typedef enum logic [18:0] {
		ST_IDLE    = 19'b0000000000000000001,
		ST_SO_RDI  = 19'b0000000000000000010,
		ST_SO_CUR  = 19'b0000000000000000100,
		ST_SO_RDJ  = 19'b0000000000000001000,
		ST_SO_CMP  = 19'b0000000000000010000,
		ST_SO_WRI  = 19'b0000000000000100000,
		ST_SU_RDI  = 19'b0000000000001000000,
		ST_SU_ARI  = 19'b0000000000010000000,
		ST_SU_SVI  = 19'b0000000000100000000,
		ST_SU_RDJ  = 19'b0000000001000000000,
		ST_SU_ARJ  = 19'b0000000010000000000,
		ST_SU_CRS  = 19'b0000000100000000000,
		ST_SU_UNI  = 19'b0000001000000000000,
		ST_SU_TLO  = 19'b0000010000000000000,
		ST_SU_THI  = 19'b0000100000000000000,
		ST_SU_CMP  = 19'b0001000000000000000,
		ST_EM_SCAN = 19'b0010000000000000000,
		ST_EM_GOT  = 19'b0100000000000000000,
		ST_EM_LAST = 19'b1000000000000000000
	} state_t;

endpackage

// ===== src/bnms_mul.sv =====
// ----------------------------------------------------------------------------
// bnms_mul
// Shared signed multiplier with operand selection for area, overlap and
// threshold products; product is registered.
// ----------------------------------------------------------------------------
module bnms_mul (
	input  logic                                   clk,
	input  bnms_pkg::mul_op_t                      op,
	input  bnms_pkg::entry_t                       box_a,
	input  bnms_pkg::entry_t                       box_b,
	input  logic [15:0]                            thr,
	input  logic signed [bnms_pkg::UNI_W-1:0]      uni,
	output logic signed [bnms_pkg::PROD_W-1:0]     prod_q
);

	localparam int EW = bnms_pkg::EXT_W;
	localparam int OW = bnms_pkg::OPD_W;

	logic signed [EW-1:0] al, ab, ar, at, bl, bb, br, bt;
	logic signed [EW-1:0] x1, y1, x2, y2, w, h;
	logic signed [OW-1:0] opa, opb;

	always_comb begin
		al = EW'(box_a.left);
		ab = EW'(box_a.bottom);
		ar = EW'(box_a.right);
		at = EW'(box_a.top);
		bl = EW'(box_b.left);
		bb = EW'(box_b.bottom);
		br = EW'(box_b.right);
		bt = EW'(box_b.top);
		x1 = (al > bl) ? al : bl;
		y1 = (ab > bb) ? ab : bb;
		x2 = (ar < br) ? ar : br;
		y2 = (at < bt) ? at : bt;
		w  = x2 - x1 + bnms_pkg::UNIT;
		h  = y2 - y1 + bnms_pkg::UNIT;
		if (w < 0) begin
			w = '0;
		end
		if (h < 0) begin
			h = '0;
		end
		case (op)
			bnms_pkg::MUL_AREA: begin
				opa = OW'(br - bl + bnms_pkg::UNIT);
				opb = OW'(bt - bb + bnms_pkg::UNIT);
			end
			bnms_pkg::MUL_CROSS: begin
				opa = OW'(w);
				opb = OW'(h);
			end
			bnms_pkg::MUL_TLO: begin
				opa = signed'(OW'({1'b0, thr}));
				opb = signed'(OW'({1'b0, uni[bnms_pkg::UNI_LO_W-1:0]}));
			end
			default: begin
				// upper part of the union keeps its sign
				opa = signed'(OW'({1'b0, thr}));
				opb = OW'(signed'(uni[bnms_pkg::UNI_W-1:bnms_pkg::UNI_LO_W]));
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

endmodule

// ===== src/box_non_maximum_suppression_core.sv =====
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_core
// Greedy non-maximum suppression over a set of scored boxes.
// ----------------------------------------------------------------------------
// Candidates come in on start while busy is low, one beat per cycle; each is
// stored until the store is full, later ones are dropped. A beat with
// final_item closes the set: busy rises, the store is exchange-sorted by
// score, greedy IoU suppression runs and the survivors go out in score order,
// one beat per result_valid pulse, at most max_outputs of them (0 acts as 1,
// above 64 as 64), end_of_set on the last. The receiver cannot stall; every
// result is taken in its cycle. Sorting compares each entry with every later
// one; suppression handles live rows and pairs and skips dead rows and
// columns (through the one shared multiplier and the single-port store);
// emission scans in score order, sends the survivors and closes the set.
// The last result appears in the cycle busy drops.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made only while busy is low. Reset empties the store and sets the
// threshold to 0.5 and max_outputs to 64.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] left_edge,
	input  logic signed [15:0] bottom_edge,
	input  logic signed [15:0] right_edge,
	input  logic signed [15:0] top_edge,
	input  logic [15:0]        confidence,
	input  logic [2:0]         class_id,
	input  logic               direction_label,
	input  logic [15:0]        box_tag,
	input  logic               final_item,
	output logic               result_valid,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_bottom,
	output logic signed [15:0] out_right,
	output logic signed [15:0] out_top,
	output logic [15:0]        out_confidence,
	output logic [2:0]         out_class,
	output logic               out_direction,
	output logic [15:0]        out_tag,
	output logic               none_kept,
	output logic               end_of_set
);

	localparam int CAP = bnms_pkg::CAPACITY;
	localparam int IW  = bnms_pkg::IDX_W;
	localparam int CW  = bnms_pkg::CNT_W;
	localparam int EW  = bnms_pkg::EMIT_W;

	bnms_pkg::state_t  state_q;
	logic [15:0]       thr_q;
	logic [6:0]        max_out_q;
	logic [CW-1:0]     count_q, i_q, j_q;
	logic [EW-1:0]     emitted_q, cap;
	logic [CAP-1:0]    alive_q;
	logic              have_pend_q;

	bnms_pkg::entry_t  mem [CAP];
	bnms_pkg::entry_t  rd_q, cur_q, pend_q, res_q, in_entry, wdata;
	logic              we, rd_en;
	logic [IW-1:0]     waddr, raddr;

	bnms_pkg::mul_op_t mop;
	logic signed [bnms_pkg::PROD_W-1:0] prod_q;
	logic signed [bnms_pkg::PROD_W-1:0] area_i_q, area_j_q, cross_q;
	logic signed [bnms_pkg::UNI_W-1:0]  uni_q;
	logic signed [bnms_pkg::ACC_W-1:0]  acc_q, rhs, lhs;

	logic              res_valid_q, res_none_q, res_end_q;
	logic              accept, i_more, j_more;

	assign accept = start && !busy;
	assign busy   = (state_q != bnms_pkg::ST_IDLE);
	assign i_more = (CW'(i_q + 1'b1) < count_q);
	assign j_more = (CW'(j_q + 1'b1) < count_q);

	always_comb begin
		if (max_out_q == '0) begin
			cap = EW'(1);
		end else if (max_out_q > EW'(bnms_pkg::MAX_EMIT)) begin
			cap = EW'(bnms_pkg::MAX_EMIT);
		end else begin
			cap = max_out_q;
		end
	end

	always_comb begin
		in_entry.left   = left_edge;
		in_entry.bottom = bottom_edge;
		in_entry.right  = right_edge;
		in_entry.top    = top_edge;
		in_entry.score  = confidence;
		in_entry.cls    = class_id;
		in_entry.dir    = direction_label;
		in_entry.tag    = box_tag;
	end

	// store port control
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IW-1:0];
		wdata = in_entry;
		rd_en = 1'b0;
		raddr = i_q[IW-1:0];
		mop   = bnms_pkg::MUL_AREA;
		case (state_q)
			bnms_pkg::ST_IDLE: begin
				we = accept && (count_q < CW'(CAP));
			end
			bnms_pkg::ST_SO_RDI, bnms_pkg::ST_SU_RDI, bnms_pkg::ST_EM_SCAN: begin
				rd_en = 1'b1;
			end
			bnms_pkg::ST_SO_RDJ, bnms_pkg::ST_SU_RDJ: begin
				rd_en = 1'b1;
				raddr = j_q[IW-1:0];
			end
			bnms_pkg::ST_SO_CMP: begin
				we    = (cur_q.score < rd_q.score);
				waddr = j_q[IW-1:0];
				wdata = cur_q;
			end
			bnms_pkg::ST_SO_WRI: begin
				we    = 1'b1;
				waddr = i_q[IW-1:0];
				wdata = cur_q;
			end
			bnms_pkg::ST_SU_CRS: begin
				mop = bnms_pkg::MUL_CROSS;
			end
			bnms_pkg::ST_SU_TLO: begin
				mop = bnms_pkg::MUL_TLO;
			end
			bnms_pkg::ST_SU_THI: begin
				mop = bnms_pkg::MUL_THI;
			end
			default: begin
				mop = bnms_pkg::MUL_AREA;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	bnms_mul u_mul (
		.clk    (clk),
		.op     (mop),
		.box_a  (cur_q),
		.box_b  (rd_q),
		.thr    (thr_q),
		.uni    (uni_q),
		.prod_q (prod_q)
	);

	assign lhs = bnms_pkg::ACC_W'(cross_q) <<< 16;
	assign rhs = acc_q + (bnms_pkg::ACC_W'(prod_q) <<< bnms_pkg::UNI_LO_W);

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			bnms_pkg::ST_SO_CUR: begin
				cur_q <= rd_q;
			end
			bnms_pkg::ST_SO_CMP: begin
				if (cur_q.score < rd_q.score) begin
					cur_q <= rd_q;
				end
			end
			bnms_pkg::ST_SU_ARI: begin
				cur_q <= rd_q;
			end
			bnms_pkg::ST_SU_SVI: begin
				area_i_q <= prod_q;
			end
			bnms_pkg::ST_SU_CRS: begin
				area_j_q <= prod_q;
			end
			bnms_pkg::ST_SU_UNI: begin
				cross_q <= prod_q;
				uni_q   <= bnms_pkg::UNI_W'(area_i_q + area_j_q - prod_q);
			end
			bnms_pkg::ST_SU_THI: begin
				acc_q <= bnms_pkg::ACC_W'(prod_q);
			end
			bnms_pkg::ST_EM_GOT: begin
				pend_q <= rd_q;
				res_q  <= pend_q;
			end
			bnms_pkg::ST_EM_LAST: begin
				res_q <= have_pend_q ? pend_q : '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bnms_pkg::ST_IDLE;
			thr_q       <= 16'd32768;
			max_out_q   <= 7'd64;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			emitted_q   <= '0;
			alive_q     <= '0;
			have_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_none_q  <= 1'b0;
			res_end_q   <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			res_none_q  <= 1'b0;
			res_end_q   <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					bnms_pkg::REG_THRESHOLD: thr_q     <= cfg_data;
					default:                 max_out_q <= cfg_data[6:0];
				endcase
			end
			case (state_q)
				bnms_pkg::ST_IDLE: begin
					if (accept) begin
						if (count_q < CW'(CAP)) begin
							count_q <= CW'(count_q + 1'b1);
						end
						if (final_item) begin
							i_q     <= '0;
							state_q <= bnms_pkg::ST_SO_RDI;
						end
					end
				end
				bnms_pkg::ST_SO_RDI: begin
					state_q <= bnms_pkg::ST_SO_CUR;
				end
				bnms_pkg::ST_SO_CUR: begin
					alive_q[i_q[IW-1:0]] <= 1'b1;
					j_q <= CW'(i_q + 1'b1);
					state_q <= i_more ? bnms_pkg::ST_SO_RDJ : bnms_pkg::ST_SO_WRI;
				end
				bnms_pkg::ST_SO_RDJ: begin
					state_q <= bnms_pkg::ST_SO_CMP;
				end
				bnms_pkg::ST_SO_CMP: begin
					j_q <= CW'(j_q + 1'b1);
					state_q <= j_more ? bnms_pkg::ST_SO_RDJ : bnms_pkg::ST_SO_WRI;
				end
				bnms_pkg::ST_SO_WRI: begin
					if (i_more) begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= bnms_pkg::ST_SO_RDI;
					end else begin
						i_q     <= '0;
						state_q <= bnms_pkg::ST_SU_RDI;
					end
				end
				bnms_pkg::ST_SU_RDI: begin
					if (alive_q[i_q[IW-1:0]]) begin
						state_q <= bnms_pkg::ST_SU_ARI;
					end else if (i_more) begin
						i_q <= CW'(i_q + 1'b1);
					end else begin
						i_q         <= '0;
						emitted_q   <= '0;
						have_pend_q <= 1'b0;
						state_q     <= bnms_pkg::ST_EM_SCAN;
					end
				end
				bnms_pkg::ST_SU_ARI: begin
					state_q <= bnms_pkg::ST_SU_SVI;
				end
				bnms_pkg::ST_SU_SVI: begin
					if (i_more) begin
						j_q     <= CW'(i_q + 1'b1);
						state_q <= bnms_pkg::ST_SU_RDJ;
					end else begin
						i_q         <= '0;
						emitted_q   <= '0;
						have_pend_q <= 1'b0;
						state_q     <= bnms_pkg::ST_EM_SCAN;
					end
				end
				bnms_pkg::ST_SU_RDJ, bnms_pkg::ST_SU_CMP: begin
					if (state_q == bnms_pkg::ST_SU_RDJ && alive_q[j_q[IW-1:0]]) begin
						state_q <= bnms_pkg::ST_SU_ARJ;
					end else begin
						if (state_q == bnms_pkg::ST_SU_CMP && lhs > rhs) begin
							alive_q[j_q[IW-1:0]] <= 1'b0;
						end
						if (j_more) begin
							j_q     <= CW'(j_q + 1'b1);
							state_q <= bnms_pkg::ST_SU_RDJ;
						end else if (i_more) begin
							i_q     <= CW'(i_q + 1'b1);
							state_q <= bnms_pkg::ST_SU_RDI;
						end else begin
							i_q         <= '0;
							emitted_q   <= '0;
							have_pend_q <= 1'b0;
							state_q     <= bnms_pkg::ST_EM_SCAN;
						end
					end
				end
				bnms_pkg::ST_SU_ARJ: begin
					state_q <= bnms_pkg::ST_SU_CRS;
				end
				bnms_pkg::ST_SU_CRS: begin
					state_q <= bnms_pkg::ST_SU_UNI;
				end
				bnms_pkg::ST_SU_UNI: begin
					state_q <= bnms_pkg::ST_SU_TLO;
				end
				bnms_pkg::ST_SU_TLO: begin
					state_q <= bnms_pkg::ST_SU_THI;
				end
				bnms_pkg::ST_SU_THI: begin
					state_q <= bnms_pkg::ST_SU_CMP;
				end
				bnms_pkg::ST_EM_SCAN: begin
					if (i_q < count_q && emitted_q < cap) begin
						if (alive_q[i_q[IW-1:0]]) begin
							state_q <= bnms_pkg::ST_EM_GOT;
						end else begin
							i_q <= CW'(i_q + 1'b1);
						end
					end else begin
						state_q <= bnms_pkg::ST_EM_LAST;
					end
				end
				bnms_pkg::ST_EM_GOT: begin
					// the held survivor goes out once a later one is found
					res_valid_q <= have_pend_q;
					have_pend_q <= 1'b1;
					emitted_q   <= EW'(emitted_q + 1'b1);
					i_q         <= CW'(i_q + 1'b1);
					state_q     <= bnms_pkg::ST_EM_SCAN;
				end
				bnms_pkg::ST_EM_LAST: begin
					res_valid_q <= 1'b1;
					res_end_q   <= 1'b1;
					res_none_q  <= !have_pend_q;
					count_q     <= '0;
					alive_q     <= '0;
					state_q     <= bnms_pkg::ST_IDLE;
				end
				default: begin
					state_q <= bnms_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = res_valid_q;
	assign none_kept      = res_none_q;
	assign end_of_set     = res_end_q;
	assign out_left       = res_q.left;
	assign out_bottom     = res_q.bottom;
	assign out_right      = res_q.right;
	assign out_top        = res_q.top;
	assign out_confidence = res_q.score;
	assign out_class      = res_q.cls;
	assign out_direction  = res_q.dir;
	assign out_tag        = res_q.tag;

endmodule

// ===== src/bnms_checker.sv =====
// ----------------------------------------------------------------------------
// bnms_checker
// Port-level checks of the suppression core, bound to the top level.
// ----------------------------------------------------------------------------
module bnms_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic final_item,
	input logic result_valid,
	input logic none_kept,
	input logic end_of_set
);

	default disable iff (!arst_n);

	// a closing beat always starts the processing pass
	a_final_busy: assert property (@(posedge clk) start && !busy && final_item |=> busy)
		else $error("busy did not rise after the last beat of a set");

	a_busy_cause: assert property (@(posedge clk) $rose(busy) |-> $past(start && final_item))
		else $error("busy rose without a closing beat");

	a_last_idle: assert property (@(posedge clk) result_valid && end_of_set |-> !busy)
		else $error("last result of a set while still busy");

	a_flags_quiet: assert property (@(posedge clk) !result_valid |-> !end_of_set && !none_kept)
		else $error("result flags without a result beat");

	a_none_end: assert property (@(posedge clk) none_kept |-> end_of_set)
		else $error("empty-set result not marked last");

endmodule

bind box_non_maximum_suppression_core bnms_checker u_bnms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.final_item   (final_item),
	.result_valid (result_valid),
	.none_kept    (none_kept),
	.end_of_set   (end_of_set)
);

// ===== bench/tb_box_non_maximum_suppression_core.sv =====
// ----------------------------------------------------------------------------
// tb_box_non_maximum_suppression_core
// Sends sets of candidate boxes and checks each survivor of greedy
// suppression against a score-sorted predictor, field by field.
// ----------------------------------------------------------------------------
module tb_box_non_maximum_suppression_core;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] left, bottom, right, top;
		logic [15:0]        score;
		logic [2:0]         cls;
		logic               dir;
		logic [15:0]        tag;
		logic               none, last;
	} survivor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = bnms_pkg::REG_THRESHOLD;
	logic [15:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] left_edge = '0, bottom_edge = '0, right_edge = '0, top_edge = '0;
	logic [15:0] confidence = '0;
	logic [2:0] class_id = '0;
	logic direction_label = 1'b0;
	logic [15:0] box_tag = '0;
	logic final_item = 1'b0;
	logic result_valid;
	logic signed [15:0] out_left, out_bottom, out_right, out_top;
	logic [15:0] out_confidence;
	logic [2:0] out_class;
	logic out_direction;
	logic [15:0] out_tag;
	logic none_kept, end_of_set;

	box_non_maximum_suppression_core u_dut (.*);

	initial forever #4 clk = ~clk;

	// predictor state
	bnms_pkg::entry_t held_boxes[$];
	logic [15:0] iou_limit = 16'd32768;
	logic [6:0]  emit_cap = 7'd64;
	survivor_t expected_survivors[$];
	int        error_count = 0;
	bit        quiet_sender = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	function automatic bit box_suppresses(bnms_pkg::entry_t a, bnms_pkg::entry_t b);
		longint al, ab, ar, at, bl, bb, br, bt, w, h, crs, uni;
		al = a.left; ab = a.bottom; ar = a.right; at = a.top;
		bl = b.left; bb = b.bottom; br = b.right; bt = b.top;
		w = ((ar < br) ? ar : br) - ((al > bl) ? al : bl) + 256;
		h = ((at < bt) ? at : bt) - ((ab > bb) ? ab : bb) + 256;
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		crs = w * h;
		uni = (ar - al + 256) * (at - ab + 256) + (br - bl + 256) * (bt - bb + 256) - crs;
		return crs * 65536 > longint'(iou_limit) * uni;
	endfunction

	function automatic void close_set();
		bnms_pkg::entry_t box[$];
		bnms_pkg::entry_t tmp;
		bit kept[$];
		int n, cap, cnt;
		survivor_t s;
		box = held_boxes;
		n = box.size();
		for (int i = 0; i < n; i++) begin
			kept.push_back(1'b1);
			for (int j = i + 1; j < n; j++)
				if (box[i].score < box[j].score) begin
					tmp = box[i]; box[i] = box[j]; box[j] = tmp;
				end
		end
		for (int i = 0; i < n; i++) begin
			if (!kept[i]) continue;
			for (int j = i + 1; j < n; j++)
				if (kept[j] && box_suppresses(box[i], box[j])) kept[j] = 1'b0;
		end
		cap = (emit_cap == 0) ? 1 :
			(emit_cap > bnms_pkg::MAX_EMIT ? bnms_pkg::MAX_EMIT : int'(emit_cap));
		cnt = 0;
		for (int i = 0; i < n && cnt < cap; i++) begin
			if (!kept[i]) continue;
			s = '{box[i].left, box[i].bottom, box[i].right, box[i].top, box[i].score,
				box[i].cls, box[i].dir, box[i].tag, 1'b0, 1'b0};
			expected_survivors.push_back(s);
			cnt++;
		end
		if (cnt == 0) begin
			s = '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1};
			expected_survivors.push_back(s);
		end else
			expected_survivors[$].last = 1'b1;
		held_boxes.delete();
	endfunction

	// result checker
	always @(posedge clk) begin
		survivor_t w;
		if (arst_n && result_valid) begin
			if (expected_survivors.size() == 0)
				report("unexpected beat", out_tag, 0);
			else begin
				w = expected_survivors.pop_front();
				if (out_left !== w.left) report("left", out_left, w.left);
				if (out_bottom !== w.bottom) report("bottom", out_bottom, w.bottom);
				if (out_right !== w.right) report("right", out_right, w.right);
				if (out_top !== w.top) report("top", out_top, w.top);
				if (out_confidence !== w.score) report("confidence", out_confidence, w.score);
				if (out_class !== w.cls) report("class", out_class, w.cls);
				if (out_direction !== w.dir) report("direction", out_direction, w.dir);
				if (out_tag !== w.tag) report("tag", out_tag, w.tag);
				if (none_kept !== w.none) report("none_kept", none_kept, w.none);
				if (end_of_set !== w.last) report("end_of_set", end_of_set, w.last);
			end
		end
	end

	// start stays high after the beat; a random gap before the next beat or drain() lowers it
	task automatic send_box(input bnms_pkg::entry_t b, input logic fin);
		while (!quiet_sender && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		left_edge <= b.left; bottom_edge <= b.bottom; right_edge <= b.right; top_edge <= b.top;
		confidence <= b.score; class_id <= b.cls; direction_label <= b.dir;
		box_tag <= b.tag; final_item <= fin;
		// busy only moves at the rising edge, so its value here decides the next edge
		while (busy) @(negedge clk);
		@(negedge clk);
		if (held_boxes.size() < bnms_pkg::CAPACITY) held_boxes.push_back(b);
		if (fin) close_set();
	endtask

	task automatic drain();
		int guard = 0;
		start <= 1'b0;
		while ((expected_survivors.size() != 0 || busy) && guard < 2000000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		drain();
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bnms_pkg::REG_THRESHOLD) iou_limit = val;
		else emit_cap = val[6:0];
	endtask

	function automatic bnms_pkg::entry_t random_box(input int span);
		bnms_pkg::entry_t b;
		int x, y;
		x = int'($urandom_range(2 * span)) - span;
		y = int'($urandom_range(2 * span)) - span;
		b.left = 16'(x); b.bottom = 16'(y);
		b.right = 16'(x + int'($urandom_range(span)));
		b.top = 16'(y + int'($urandom_range(span)));
		b.score = 16'($urandom); b.cls = 3'($urandom); b.dir = 1'($urandom);
		b.tag = 16'($urandom);
		return b;
	endfunction

	task automatic send_set(input int n, input int span);
		for (int i = 0; i < n; i++)
			send_box(random_box(span), i == n - 1);
	endtask

	task automatic test_extremes();
		bnms_pkg::entry_t b;
		b = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 3'd7, 1'b1, 16'hffff};
		send_box(b, 1'b0);
		b = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'h0000, 3'd0, 1'b0, 16'h0000};
		send_box(b, 1'b0);  // inverted box
		b = '{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100, 16'hffff, 3'd5, 1'b0, 16'h1234};
		send_box(b, 1'b0);  // equal score to the first
		b = '{16'sh0010, 16'sh0010, 16'sh0100, 16'sh0100, 16'h8000, 3'd2, 1'b1, 16'habcd};
		send_box(b, 1'b1);
		b = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'h0001, 3'd3, 1'b1, 16'h5555};
		send_box(b, 1'b1);  // single-candidate set
	endtask

	task automatic test_overflow();
		// fill past capacity; the dropped beat still closes the set
		send_set(bnms_pkg::CAPACITY + 3, 4096);
	endtask

	task automatic test_thresholds();
		write_reg(bnms_pkg::REG_THRESHOLD, 16'd0);
		send_set(6, 512);
		write_reg(bnms_pkg::REG_THRESHOLD, 16'hffff);
		send_set(6, 512);
		write_reg(bnms_pkg::REG_MAX_OUT, 16'd0);
		send_set(5, 20000);
		write_reg(bnms_pkg::REG_MAX_OUT, 16'd127);
		send_set(5, 20000);
		write_reg(bnms_pkg::REG_MAX_OUT, 16'd1);
		send_set(5, 20000);
		write_reg(bnms_pkg::REG_MAX_OUT, 16'd64);
		write_reg(bnms_pkg::REG_THRESHOLD, 16'd32768);
	endtask

	task automatic test_random();
		int total = 0;
		int n;
		while (total < 200) begin
			if ($urandom_range(9) == 0) write_reg(bnms_pkg::REG_THRESHOLD, 16'($urandom));
			if ($urandom_range(9) == 0)
				write_reg(bnms_pkg::REG_MAX_OUT, 16'($urandom_range(1, 64)));
			quiet_sender = (total > 80 && total < 130);
			n = $urandom_range(1, 12);
			send_set(n, $urandom_range(3) == 0 ? 32767 : 1024);
			total += n;
		end
		quiet_sender = 1'b0;
	endtask

	task automatic test_pause();
		send_set(4, 800);
		drain();
		send_set(4, 800);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_overflow();
		test_thresholds();
		test_pause();
		test_random();
		drain();
		if (error_count == 0 && expected_survivors.size() == 0)
			$display("TEST PASSED");
		else begin
			if (expected_survivors.size() != 0) report("missing beats", expected_survivors.size(), 0);
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
